// ----- design/mas_pkg.sv -----
package mas_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] FC_READ    = 8'h03;
  localparam logic [7:0] FC_WRITE   = 8'h10;
  localparam logic [7:0] EXC_FUNC   = 8'h01;
  localparam logic [7:0] EXC_ADDR   = 8'h02;
  localparam logic [7:0] EXC_FLAG   = 8'h80;

  localparam logic [1:0] REQ_RX    = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_char;
    logic [4:0]  reg_index;
    logic [15:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_char;
    logic        tx_last;
    logic [15:0] read_value;
    logic [15:0] error_count;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RX,
    OP_LREAD,
    OP_LANSWER,
    OP_LWRITE,
    OP_DECIDE,
    OP_SECOND,
    OP_THIRD,
    OP_LRC,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       serve_go;
    logic       out_free;
    logic       emit_last;
    logic [1:0] req_type;
  } dp_stat_t;

endpackage

// ----- design/mas_ctrl.sv -----
module mas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mas_pkg::dp_stat_t stat,
  output mas_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_LANS, S_SRV1, S_SRV2, S_SRV3, S_LRC, S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = mas_pkg::OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = mas_pkg::OP_CLEAR;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = mas_pkg::OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.req_type)
          mas_pkg::REQ_RX: begin
            cmd.op     = mas_pkg::OP_RX;
            state_next = stat.serve_go ? S_SRV1 : S_IDLE;
          end
          mas_pkg::REQ_READ: begin
            cmd.op     = mas_pkg::OP_LREAD;
            state_next = S_LANS;
          end
          mas_pkg::REQ_WRITE: begin
            if (stat.out_free) begin
              cmd.op     = mas_pkg::OP_LWRITE;
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LANS: begin
        if (stat.out_free) begin
          cmd.op     = mas_pkg::OP_LANSWER;
          state_next = S_IDLE;
        end
      end
      S_SRV1: begin
        cmd.op     = mas_pkg::OP_DECIDE;
        state_next = S_SRV2;
      end
      S_SRV2: begin
        cmd.op     = mas_pkg::OP_SECOND;
        state_next = S_SRV3;
      end
      S_SRV3: begin
        cmd.op     = mas_pkg::OP_THIRD;
        state_next = S_LRC;
      end
      S_LRC: begin
        cmd.op     = mas_pkg::OP_LRC;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = mas_pkg::OP_EMIT;
          if (stat.emit_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input accepted during register clearing");

endmodule

// ----- design/mas_dp.sv -----
module mas_dp #(
  parameter int REG_COUNT        = 32,
  parameter int FRAME_CHARS      = 64,
  parameter int MAX_REGS_PER_REQ = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  mas_pkg::in_item_t  in_data,
  input  mas_pkg::dp_cmd_t   cmd,
  output mas_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output mas_pkg::out_item_t out_data
);

  localparam int AW = $clog2(REG_COUNT);
  localparam int CW = $clog2(FRAME_CHARS);

  typedef enum logic [1:0] {K_EXC1, K_EXC2, K_READ, K_WRITE} srv_kind_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    logic [7:0] d;
    d = ch - 8'h37;
    if (ch >= 8'h30 && ch <= 8'h39) return ch[3:0];
    if (ch >= 8'h41 && ch <= 8'h46) return d[3:0];
    return 4'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'b0, v} : 8'h37 + {4'b0, v};
  endfunction

  logic [7:0]        slave_address;
  mas_pkg::in_item_t ld;
  logic              phase;
  logic [CW-1:0]     char_count;
  logic [3:0]        pend_hi;
  logic [7:0]        last_char;
  logic [7:0]        byte_sum;
  logic [7:0]        fb [16];
  logic [15:0]       mem [REG_COUNT];
  logic [15:0]       q;
  logic [AW-1:0]     clr_addr;
  logic [15:0]       error_total;
  srv_kind_t         kind, kind_next;
  logic [7:0]        rep [8];
  logic [3:0]        rep_len;
  logic [4:0]        ci;

  logic              is_colon, full, frame_end, frame_ok, err_inc;
  logic [CW-1:0]     hex, nb;
  logic [7:0]        new_byte;
  logic [7:0]        rq [1:10];
  logic [7:0]        fc;
  logic [15:0]       start, cnt;
  logic              cnt2, range_bad;
  logic [AW-1:0]     saddr, laddr, raddr, waddr;
  logic              lin, we;
  logic [15:0]       wdata;
  logic [7:0]        lrc_sum, emit_char, emit_byte;
  logic [4:0]        clen, jm;
  logic              push;
  mas_pkg::out_item_t push_item;
  mas_pkg::dp_op_t   op;

  assign op = cmd.op;

  // Receive-side decode of the latched character.
  assign is_colon  = (ld.rx_char == mas_pkg::CHAR_COLON);
  assign full      = (char_count >= CW'(FRAME_CHARS - 2));
  assign frame_end = (ld.rx_char == mas_pkg::CHAR_LF) && (last_char == mas_pkg::CHAR_CR) &&
                     (char_count != '0);
  assign hex       = char_count - CW'(1);
  assign frame_ok  = !hex[0] && (hex >= CW'(6)) && (byte_sum == 8'd0);
  assign new_byte  = {pend_hi, nibble_of(ld.rx_char)};
  assign nb        = hex >> 1;

  // Request fields; bytes past the received data read as zero.
  always_comb begin
    for (int i = 1; i <= 10; i++) begin
      rq[i] = (CW'(i + 1) < nb) ? fb[i] : 8'd0;
    end
  end

  assign fc        = rq[1];
  assign start     = {rq[2], rq[3]};
  assign cnt       = {rq[4], rq[5]};
  assign cnt2      = (cnt == 16'd2);
  assign range_bad = (cnt == 16'd0) || (cnt > 16'(MAX_REGS_PER_REQ)) ||
                     (32'(start) > 32'(REG_COUNT - 1)) ||
                     (32'(start) + 32'(cnt) > 32'(REG_COUNT));
  assign saddr     = start[AW-1:0];

  always_comb begin
    if (fc != mas_pkg::FC_READ && fc != mas_pkg::FC_WRITE) begin
      kind_next = K_EXC1;
    end else if (range_bad ||
                 (fc == mas_pkg::FC_WRITE && {9'b0, rq[6]} != {cnt, 1'b0})) begin
      kind_next = K_EXC2;
    end else if (fc == mas_pkg::FC_READ) begin
      kind_next = K_READ;
    end else begin
      kind_next = K_WRITE;
    end
  end

  assign lin   = (int'(ld.reg_index) < REG_COUNT);
  assign laddr = AW'(ld.reg_index);

  always_comb begin
    we    = 1'b0;
    waddr = laddr;
    wdata = ld.reg_value;
    raddr = laddr;
    case (op)
      mas_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = 16'd0;
      end
      mas_pkg::OP_LWRITE: we = lin;
      mas_pkg::OP_DECIDE: begin
        raddr = saddr;
        if (kind_next == K_WRITE) begin
          we    = 1'b1;
          waddr = saddr;
          wdata = {rq[7], rq[8]};
        end
      end
      mas_pkg::OP_SECOND: begin
        raddr = saddr + AW'(1);
        if (kind == K_WRITE && cnt2) begin
          we    = 1'b1;
          waddr = saddr + AW'(1);
          wdata = {rq[9], rq[10]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    q <= mem[raddr];
  end

  always_comb begin
    lrc_sum = 8'd0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < rep_len) lrc_sum = lrc_sum + rep[j];
    end
  end

  // Reply character: colon, two hex digits per byte, CR, LF.
  assign clen      = {rep_len, 1'b0};
  assign jm        = ci - 5'd1;
  assign emit_byte = rep[jm[3:1]];
  always_comb begin
    if (ci == 5'd0) begin
      emit_char = mas_pkg::CHAR_COLON;
    end else if (ci <= clen) begin
      emit_char = hex_char(jm[0] ? emit_byte[3:0] : emit_byte[7:4]);
    end else if (ci == clen + 5'd1) begin
      emit_char = mas_pkg::CHAR_CR;
    end else begin
      emit_char = mas_pkg::CHAR_LF;
    end
  end

  always_comb begin
    push                  = 1'b0;
    push_item.out_kind    = 1'b1;
    push_item.tx_char     = 8'd0;
    push_item.tx_last     = 1'b1;
    push_item.read_value  = 16'd0;
    push_item.error_count = error_total;
    case (op)
      mas_pkg::OP_LANSWER: begin
        push                 = 1'b1;
        push_item.read_value = lin ? q : 16'd0;
      end
      mas_pkg::OP_LWRITE: begin
        push                 = 1'b1;
        push_item.read_value = lin ? ld.reg_value : 16'd0;
      end
      mas_pkg::OP_EMIT: begin
        push              = 1'b1;
        push_item.out_kind = 1'b0;
        push_item.tx_char = emit_char;
        push_item.tx_last = (ci == clen + 5'd2);
      end
      default: ;
    endcase
  end

  always_comb begin
    err_inc = 1'b0;
    if (op == mas_pkg::OP_RX && phase) begin
      err_inc = is_colon || full || (frame_end && !frame_ok);
    end else if (op == mas_pkg::OP_DECIDE) begin
      err_inc = (kind_next == K_EXC1) || (kind_next == K_EXC2);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      phase         <= 1'b0;
      char_count    <= '0;
      clr_addr      <= '0;
      error_total   <= 16'd0;
      out_valid     <= 1'b0;
      kind          <= K_EXC1;
      rep_len       <= 4'd0;
      ci            <= 5'd0;
    end else begin
      if (cfg_we) slave_address <= cfg_wdata;
      if (err_inc) error_total <= error_total + 16'd1;
      if (op == mas_pkg::OP_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (op == mas_pkg::OP_RX) begin
        if (is_colon) begin
          phase      <= 1'b1;
          char_count <= '0;
        end else if (phase) begin
          if (full || frame_end) begin
            phase <= 1'b0;
          end else begin
            char_count <= char_count + CW'(1);
          end
        end
      end
      if (op == mas_pkg::OP_DECIDE) begin
        kind <= kind_next;
        case (kind_next)
          K_READ:  rep_len <= cnt2 ? 4'd7 : 4'd5;
          K_WRITE: rep_len <= 4'd6;
          default: rep_len <= 4'd3;
        endcase
      end
      if (op == mas_pkg::OP_LRC) begin
        rep_len <= rep_len + 4'd1;
        ci      <= 5'd0;
      end
      if (op == mas_pkg::OP_EMIT) ci <= ci + 5'd1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (op == mas_pkg::OP_LOAD) ld <= in_data;
    if (push) out_data <= push_item;
    if (op == mas_pkg::OP_RX) begin
      if (is_colon) begin
        pend_hi   <= 4'd0;
        last_char <= mas_pkg::CHAR_COLON;
        byte_sum  <= 8'd0;
      end else if (phase && !full && !frame_end) begin
        if (!char_count[0]) begin
          pend_hi <= nibble_of(ld.rx_char);
        end else begin
          if ((char_count >> 5) == '0) fb[char_count[4:1]] <= new_byte;
          byte_sum <= byte_sum + new_byte;
        end
        last_char <= ld.rx_char;
      end
    end
    if (op == mas_pkg::OP_DECIDE) begin
      rep[0] <= slave_address;
      case (kind_next)
        K_EXC1: begin
          rep[1] <= fc | mas_pkg::EXC_FLAG;
          rep[2] <= mas_pkg::EXC_FUNC;
        end
        K_EXC2: begin
          rep[1] <= fc | mas_pkg::EXC_FLAG;
          rep[2] <= mas_pkg::EXC_ADDR;
        end
        K_READ: begin
          rep[1] <= mas_pkg::FC_READ;
          rep[2] <= {cnt[6:0], 1'b0};
        end
        default: begin
          rep[1] <= rq[1];
          rep[2] <= rq[2];
          rep[3] <= rq[3];
          rep[4] <= rq[4];
          rep[5] <= rq[5];
        end
      endcase
    end
    if (op == mas_pkg::OP_SECOND && kind == K_READ) begin
      rep[3] <= q[15:8];
      rep[4] <= q[7:0];
    end
    if (op == mas_pkg::OP_THIRD && kind == K_READ && cnt2) begin
      rep[5] <= q[15:8];
      rep[6] <= q[7:0];
    end
    if (op == mas_pkg::OP_LRC) rep[rep_len[2:0]] <= 8'd0 - lrc_sum;
  end

  assign stat.clear_done = (clr_addr == AW'(REG_COUNT - 1));
  assign stat.serve_go   = (op == mas_pkg::OP_RX) && phase && !is_colon && !full &&
                           frame_end && frame_ok && (fb[0] == slave_address);
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.emit_last  = (ci == clen + 5'd2);
  assign stat.req_type   = ld.req_type;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("result pushed over an untaken item");

  a_err_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(error_total)) |-> (error_total == $past(error_total) + 16'd1))
    else $error("error counter moved by more than one");

  a_last_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tx_last && !out_data.out_kind) |->
      (out_data.tx_char == mas_pkg::CHAR_LF))
    else $error("reply run closed on a character other than LF");

endmodule

// ----- design/modbus_ascii_slave.sv -----
// Channel   Direction  Handshake              Item
// in        input      in_valid / in_ready    mas_pkg::in_item_t
// out       output     out_valid / out_ready  mas_pkg::out_item_t
// cfg       input      cfg_we (no wait)       slave_address
//
// A serial character passes S_IDLE and S_EXEC; a local read also S_LANS.
// A served frame adds decode, register access and LRC (S_SRV1 to S_LRC), then
// one reply character per cycle (up to 19), set by the single output register.
// After reset the holding registers are cleared, one per cycle, in S_CLEAR;
// no item is accepted meanwhile. Output stalls hold the sequencer.
module modbus_ascii_slave #(
  parameter int REG_COUNT        = 32,
  parameter int FRAME_CHARS      = 64,
  parameter int MAX_REGS_PER_REQ = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  mas_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mas_pkg::out_item_t out_data
);

  mas_pkg::dp_cmd_t  cmd;
  mas_pkg::dp_stat_t stat;

  mas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mas_dp #(
    .REG_COUNT        (REG_COUNT),
    .FRAME_CHARS      (FRAME_CHARS),
    .MAX_REGS_PER_REQ (MAX_REGS_PER_REQ)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- test/tb_modbus_ascii_slave.sv -----
module tb_modbus_ascii_slave;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREGS = 32;
  localparam int MAX_CHARS = 64;
  localparam int MAX_PER_REQ = 2;
  localparam int LIMIT = 400000;

  logic clk, rst;
  logic cfg_we;
  logic [7:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  mas_pkg::in_item_t in_data;
  mas_pkg::out_item_t out_data;

  modbus_ascii_slave DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predictor state.
  logic [7:0] own_addr;
  logic receiving;
  int unsigned rx_count;
  logic [7:0] frame_buf [16];
  logic [15:0] regs [NREGS];
  logic [15:0] err_total;
  logic [3:0] high_nib;
  logic [7:0] prev_char;
  logic [7:0] lrc_acc;

  mas_pkg::out_item_t reply_q [$];
  int sender_idle, receiver_idle;
  bit hold_off;
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [3:0] nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] hexc(input logic [3:0] v);
    return v < 10 ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] frame_byte(input int i, input int nbytes);
    if (i + 1 < nbytes && i < 16) return frame_buf[i];
    return 8'd0;
  endfunction

  task automatic push_char(input logic [7:0] c, input bit last);
    mas_pkg::out_item_t r;
    r = '0;
    r.tx_char = c;
    r.tx_last = last;
    reply_q.push_back(r);
  endtask

  task automatic serve_request(input int nbytes);
    logic [7:0] rep [$];
    logic [7:0] fc, sum;
    int unsigned first, cnt;
    bit bad;
    logic [15:0] v;
    int base;
    fc = frame_byte(1, nbytes);
    first = {frame_byte(2, nbytes), frame_byte(3, nbytes)};
    cnt = {frame_byte(4, nbytes), frame_byte(5, nbytes)};
    bad = cnt == 0 || cnt > MAX_PER_REQ || first > NREGS - 1 || first + cnt - 1 > NREGS - 1;
    rep.push_back(own_addr);
    if (fc != mas_pkg::FC_READ && fc != mas_pkg::FC_WRITE) begin
      rep.push_back(fc | mas_pkg::EXC_FLAG);
      rep.push_back(mas_pkg::EXC_FUNC);
      err_total++;
    end else begin
      if (fc == mas_pkg::FC_WRITE && frame_byte(6, nbytes) != 8'(2 * cnt)) bad = 1;
      if (bad) begin
        rep.push_back(fc | mas_pkg::EXC_FLAG);
        rep.push_back(mas_pkg::EXC_ADDR);
        err_total++;
      end else if (fc == mas_pkg::FC_READ) begin
        rep.push_back(mas_pkg::FC_READ);
        rep.push_back(8'(2 * cnt));
        for (int i = 0; i < cnt; i++) begin
          v = regs[(first + i) % NREGS];
          rep.push_back(v[15:8]);
          rep.push_back(v[7:0]);
        end
      end else begin
        for (int i = 0; i < cnt; i++) begin
          regs[(first + i) % NREGS] = {frame_byte(7 + 2 * i, nbytes),
                                       frame_byte(8 + 2 * i, nbytes)};
        end
        for (int i = 1; i <= 5; i++) rep.push_back(frame_byte(i, nbytes));
      end
    end
    sum = 0;
    foreach (rep[i]) sum += rep[i];
    rep.push_back(8'(0 - sum));
    base = reply_q.size();
    push_char(mas_pkg::CHAR_COLON, 0);
    foreach (rep[i]) begin
      push_char(hexc(rep[i][7:4]), 0);
      push_char(hexc(rep[i][3:0]), 0);
    end
    push_char(mas_pkg::CHAR_CR, 0);
    push_char(mas_pkg::CHAR_LF, 1);
    for (int i = base; i < reply_q.size(); i++) reply_q[i].error_count = err_total;
  endtask

  task automatic open_frame();
    receiving = 1;
    rx_count = 0;
    high_nib = 0;
    prev_char = mas_pkg::CHAR_COLON;
    lrc_acc = 0;
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [7:0] b;
    int unsigned hex;
    if (!receiving) begin
      if (c == mas_pkg::CHAR_COLON) open_frame();
      return;
    end
    if (c == mas_pkg::CHAR_COLON) begin
      err_total++;
      open_frame();
      return;
    end
    if (rx_count >= MAX_CHARS - 2) begin
      err_total++;
      receiving = 0;
      return;
    end
    if (c == mas_pkg::CHAR_LF && prev_char == mas_pkg::CHAR_CR && rx_count >= 1) begin
      hex = rx_count - 1;
      receiving = 0;
      if (hex[0] || hex < 6 || lrc_acc != 0) begin
        err_total++;
        return;
      end
      if (frame_buf[0] != own_addr) return;
      serve_request(hex >> 1);
      return;
    end
    if (!rx_count[0]) high_nib = nib(c);
    else begin
      b = {high_nib, nib(c)};
      if ((rx_count >> 1) < 16) frame_buf[rx_count >> 1] = b;
      lrc_acc += b;
    end
    rx_count++;
    prev_char = c;
  endtask

  task automatic predict(input mas_pkg::in_item_t it);
    mas_pkg::out_item_t r;
    r = '0;
    r.out_kind = 1;
    r.tx_last = 1;
    case (it.req_type)
      mas_pkg::REQ_RX: take_char(it.rx_char);
      mas_pkg::REQ_READ: begin
        r.read_value = regs[it.reg_index];
        r.error_count = err_total;
        reply_q.push_back(r);
      end
      mas_pkg::REQ_WRITE: begin
        regs[it.reg_index] = it.reg_value;
        r.read_value = it.reg_value;
        r.error_count = err_total;
        reply_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Output checker.
  always @(posedge clk) begin
    mas_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_data.out_kind !== want.out_kind || out_data.tx_char !== want.tx_char ||
            out_data.tx_last !== want.tx_last || out_data.read_value !== want.read_value ||
            out_data.error_count !== want.error_count) begin
          $display("%0t: expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  // Receiver readiness.
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready <= !hold_off && ($urandom_range(99) >= receiver_idle);
    end
  end

  // Returns at the falling edge after the item is taken, leaving valid high so
  // that the next item can follow at once; drain drops valid.
  task automatic send(input mas_pkg::in_item_t it);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    mas_pkg::in_item_t it;
    it = '0;
    it.req_type = mas_pkg::REQ_RX;
    it.rx_char = c;
    it.reg_index = 5'($urandom);
    it.reg_value = 16'($urandom);
    send(it);
  endtask

  // Sends a frame with correct LRC; lrc_err corrupts the checksum.
  task automatic send_frame(input logic [7:0] body [$], input bit lrc_err);
    logic [7:0] s;
    s = 0;
    foreach (body[i]) s += body[i];
    body.push_back(8'(0 - s) ^ (lrc_err ? 8'h01 : 8'h00));
    send_char(mas_pkg::CHAR_COLON);
    foreach (body[i]) begin
      send_char(hexc(body[i][7:4]));
      send_char(hexc(body[i][3:0]));
    end
    send_char(mas_pkg::CHAR_CR);
    send_char(mas_pkg::CHAR_LF);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_addr(input logic [7:0] a);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= a;
    @(negedge clk);
    cfg_we <= 0;
    own_addr = a;
  endtask

  task automatic random_frame();
    logic [7:0] body [$];
    int pick;
    pick = $urandom_range(9);
    body.push_back(pick == 0 ? 8'($urandom) : own_addr);
    if (pick == 1) body.push_back(8'($urandom));
    else body.push_back($urandom_range(1) ? mas_pkg::FC_READ : mas_pkg::FC_WRITE);
    body.push_back(pick == 2 ? 8'($urandom) : 8'h00);
    body.push_back(pick == 3 ? 8'($urandom) : 8'($urandom_range(NREGS - 1)));
    body.push_back(8'h00);
    body.push_back(pick == 4 ? 8'($urandom_range(3)) : 8'($urandom_range(2, 1)));
    if (body[1] == mas_pkg::FC_WRITE) begin
      body.push_back(pick == 5 ? 8'($urandom_range(5)) : 8'(2 * body[5]));
      for (int i = 0; i < 4; i++) body.push_back(8'($urandom));
    end
    send_frame(body, pick == 6);
  endtask

  typedef struct {
    mas_pkg::in_item_t item;
    bit known;
    mas_pkg::out_item_t want;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    mas_pkg::in_item_t it;
    mas_pkg::out_item_t got;
    logic [7:0] body [$];
    hold_off = 0;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_data = '0;
    sender_idle = 6;
    receiver_idle = 82;
    own_addr = 1;
    receiving = 0;
    rx_count = 0;
    high_nib = 0;
    prev_char = 0;
    lrc_acc = 0;
    err_total = 0;
    foreach (frame_buf[i]) frame_buf[i] = 0;
    foreach (regs[i]) regs[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed table: local accesses at extremes, an undefined request type and a stray character.
    rw.known = 1;
    rw.want = '0;
    rw.want.out_kind = 1;
    rw.want.tx_last = 1;
    rw.item = '{mas_pkg::REQ_READ, 8'h00, 5'd0, 16'h0};
    rows.push_back(rw);
    rw.item = '{mas_pkg::REQ_READ, 8'hFF, 5'd31, 16'hFFFF};
    rows.push_back(rw);
    rw.item = '{mas_pkg::REQ_WRITE, 8'h00, 5'd31, 16'hFFFF};
    rw.want.read_value = 16'hFFFF;
    rows.push_back(rw);
    rw.item = '{mas_pkg::REQ_WRITE, 8'hFF, 5'd0, 16'h0000};
    rw.want.read_value = 16'h0000;
    rows.push_back(rw);
    rw.known = 0;
    rw.item = '{mas_pkg::REQ_READ, 8'h00, 5'd31, 16'h0};
    rows.push_back(rw);
    rw.item = '{2'd3, 8'hFF, 5'd31, 16'hFFFF};
    rows.push_back(rw);
    rw.item = '{mas_pkg::REQ_RX, 8'hFF, 5'd0, 16'h0};
    rows.push_back(rw);
    foreach (rows[i]) begin
      if (rows[i].known) begin
        it = rows[i].item;
        send(it);
        got = '0;
        if (reply_q.size() != 0) got = reply_q[$];
        if (reply_q.size() == 0 || got != rows[i].want) begin
          $display("%0t: expected %p actual %p", $time, rows[i].want, got);
          errors++;
        end
      end else send(rows[i].item);
    end

    // Directed frames: write, read, bad function, bad range, zero count, bad LRC,
    // short frame, restarting colon, lowercase, overflow.
    body = '{8'h01, mas_pkg::FC_WRITE, 8'h00, 8'h1E, 8'h00, 8'h02, 8'h04, 8'hAB, 8'hCD,
             8'h12, 8'h34};
    send_frame(body, 0);
    body = '{8'h01, mas_pkg::FC_READ, 8'h00, 8'h1E, 8'h00, 8'h02};
    send_frame(body, 0);
    body = '{8'h01, 8'h07, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(body, 0);
    body = '{8'h01, mas_pkg::FC_READ, 8'h00, 8'h1F, 8'h00, 8'h02};
    send_frame(body, 0);
    body = '{8'h01, mas_pkg::FC_READ, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(body, 0);
    body = '{8'h01, mas_pkg::FC_READ, 8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(body, 1);
    body = '{8'h01, mas_pkg::FC_READ};
    send_frame(body, 0);
    send_char(mas_pkg::CHAR_COLON);
    send_char("0");
    send_char(":");
    send_char("a");
    send_char("b");
    send_char(mas_pkg::CHAR_CR);
    send_char(mas_pkg::CHAR_LF);
    send_char(mas_pkg::CHAR_COLON);
    repeat (MAX_CHARS - 1) send_char("F");
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_addr(8'hFF);
        1: set_addr(8'h00);
        default: set_addr(8'($urandom_range(254, 2)));
      endcase
      if (phase == 1) begin
        sender_idle = 82;
        receiver_idle = 6;
      end else if (phase >= 2) begin
        sender_idle = 0;
        receiver_idle = 0;
      end
      case ($urandom_range(9))
        0: begin
          it = '0;
          it.req_type = 2'($urandom_range(3));
          it.rx_char = 8'($urandom);
          it.reg_index = 5'($urandom);
          it.reg_value = 16'($urandom);
          send(it);
        end
        1: repeat ($urandom_range(4, 1)) send_char($urandom_range(1) ? 8'($urandom)
                                                   : hexc(4'($urandom)));
        default: random_frame();
      endcase
      drain();
    end

    // Long receiver hold-off while items keep arriving.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        body = '{own_addr, mas_pkg::FC_READ, 8'h00, 8'h00, 8'h00, 8'h02};
        send_frame(body, 0);
        repeat (4) begin
          it = '0;
          it.req_type = mas_pkg::REQ_READ;
          it.reg_index = 5'($urandom);
          send(it);
        end
      end
    join
    drain();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
